// ===== rtl/cdl_pkg.sv =====
// Package for the circular deque list: request and status codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package cdl_pkg;

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_REM_FRONT = 3'd3;
    localparam logic [2:0] REQ_REM_BACK  = 3'd4;
    localparam logic [2:0] REQ_REM_POS   = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MOVE,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;    // latch the request on an input transfer
        logic setup;      // check request, load pointers and move counter
        logic read_first; // first store read of a run
        logic move;       // take read data, read the next entry
        logic put;        // write the new word
        logic commit;     // update head/count, load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic chk_err;    // request refused
        logic chk_nomove; // no entry to read
        logic chk_ins;    // request is an insert (check cycle)
        logic req_ins;    // request is an insert (registered)
        logic left_zero;  // no reads left in the run
    } t_dp_stat;

endpackage

// ===== rtl/cdl_ifs.sv =====
// Valid/ready channel interfaces for the circular deque list: request and
// response. Depends on nothing.
interface cdl_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  req_type;
    logic signed [31:0] data_in;
    logic        [4:0]  position;

    modport source (output valid, req_type, data_in, position, input ready);
    modport sink   (input valid, req_type, data_in, position, output ready);
endinterface

interface cdl_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] data_out;
    logic        [4:0]  count;

    modport source (output valid, status, data_out, count, input ready);
    modport sink   (input valid, status, data_out, count, output ready);
endinterface

// ===== rtl/circular_deque_list.sv =====
// Circular deque list, top level; uses cdl_pkg, cdl_ifs, cdl_ctrl and cdl_datapath.
// Each request is checked; a refused one goes straight to the result, a front/back insert
// writes its word, a removal makes N = count - position store reads, a positional insert
// makes those reads, then writes (N = 1 for front/back removes, none for an insert at the
// back). Requests are taken one at a time, after the last result commits; response stalls hold it.
// Synchronous active-low reset clears head, count and handshake state; store undefined.
module circular_deque_list
    import cdl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cdl_req_if.sink   i_req,
    cdl_rsp_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    cdl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_type (i_req.req_type),
        .i_data_in  (i_req.data_in),
        .i_position (i_req.position),
        .o_status   (o_rsp.status),
        .o_data_out (o_rsp.data_out),
        .o_count    (o_rsp.count)
    );

endmodule

// ===== rtl/cdl_datapath.sv =====
// Datapath of the circular deque list: entry store, head and count, shift
// pointers and the result register. Uses cdl_pkg; driven by cdl_ctrl.
module cdl_datapath
    import cdl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic        [2:0]  i_req_type,
    input  logic signed [31:0] i_data_in,
    input  logic        [4:0]  i_position,
    output logic        [1:0]  o_status,
    output logic signed [31:0] o_data_out,
    output logic        [4:0]  o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [CW:0]   CAP_X    = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    logic [31:0] mem [CAPACITY];

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [2:0]    r_req_type;
    logic [31:0]   r_data;
    logic [PW-1:0] r_pos;
    logic [1:0]    r_status;
    logic          r_ins;
    logic          r_take;
    logic          r_up;
    logic [CW-1:0] r_left;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_wp;
    logic [31:0]   r_rdata;
    logic [31:0]   r_removed;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_data;
    logic [4:0]    r_o_count;

    logic [1:0]    chk_status;
    logic          chk_ins;
    logic [CW-1:0] init_left;
    logic [AW-1:0] init_rp;
    logic [AW-1:0] init_wp;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] pos_c;
    logic [PW-1:0] cnt_x;
    logic [CW-1:0] n_count;
    logic [AW-1:0] n_head;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;

    // slot of logical index k; head + k stays below twice the capacity
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW + 1)'(base) + {1'b0, k};
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_IDX : p - AW'(1);
    endfunction

    assign cnt_m1 = r_count - CW'(1);
    assign pos_c  = r_pos[CW-1:0];
    assign cnt_x  = PW'(r_count);

    always_comb begin
        chk_status = ST_DONE;
        chk_ins    = 1'b0;
        init_left  = '0;
        init_rp    = f_slot(r_head, pos_c);
        init_wp    = f_slot(r_head, r_count);
        unique case (r_req_type)
            REQ_INS_FRONT: begin
                chk_ins = 1'b1;
                init_wp = f_dec(r_head);
                if (r_count == CAP_C) chk_status = ST_FULL;
            end
            REQ_INS_BACK: begin
                chk_ins = 1'b1;
                if (r_count == CAP_C) chk_status = ST_FULL;
            end
            REQ_INS_POS: begin
                chk_ins   = 1'b1;
                init_left = r_count - pos_c;
                init_rp   = f_slot(r_head, cnt_m1);
                if (r_pos > cnt_x) begin
                    chk_status = ST_RANGE;
                end else if (r_count == CAP_C) begin
                    chk_status = ST_FULL;
                end
            end
            REQ_REM_FRONT: begin
                init_left = CW'(1);
                init_rp   = r_head;
                if (r_count == '0) chk_status = ST_RANGE;
            end
            REQ_REM_BACK: begin
                init_left = CW'(1);
                init_rp   = f_slot(r_head, cnt_m1);
                if (r_count == '0) chk_status = ST_RANGE;
            end
            REQ_REM_POS: begin
                // first word read is the removed one, the rest move down
                init_left = r_count - pos_c;
                init_wp   = f_slot(r_head, pos_c);
                if (r_pos >= cnt_x) chk_status = ST_RANGE;
            end
            default: begin
                chk_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        if (r_status == ST_DONE) begin
            n_count = r_ins ? r_count + CW'(1) : cnt_m1;
            if (r_req_type == REQ_INS_FRONT) n_head = f_dec(r_head);
            if (r_req_type == REQ_REM_FRONT) n_head = f_inc(r_head);
        end
    end

    assign o_stat.chk_err    = (chk_status != ST_DONE);
    assign o_stat.chk_nomove = (init_left == '0);
    assign o_stat.chk_ins    = chk_ins;
    assign o_stat.req_ins    = r_ins;
    assign o_stat.left_zero  = (r_left == '0);

    // store port usage
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_data = r_rdata;
        if (i_cmd.move && !r_take) begin
            wr_en = 1'b1;
        end else if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_data = r_data;
        end
        rd_en = i_cmd.read_first || (i_cmd.move && (r_left != '0));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[r_rp];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_take  <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_take <= !chk_ins;
            end else if (i_cmd.move) begin
                r_take <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    // request, pointers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_data     <= i_data_in;
            r_pos      <= PW'(i_position);
        end
        if (i_cmd.setup) begin
            r_status <= chk_status;
            r_ins    <= chk_ins;
            r_up     <= !chk_ins;
            r_left   <= init_left;
            r_rp     <= init_rp;
            r_wp     <= init_wp;
        end
        if (rd_en) begin
            r_rp   <= r_up ? f_inc(r_rp) : f_dec(r_rp);
            r_left <= r_left - CW'(1);
        end
        if (i_cmd.move) begin
            if (r_take) begin
                r_removed <= r_rdata;
            end else begin
                r_wp <= r_up ? f_inc(r_wp) : f_dec(r_wp);
            end
        end
        if (i_cmd.commit) begin
            r_o_status <= r_status;
            r_o_data   <= (r_status == ST_DONE && !r_ins) ? r_removed : '0;
            r_o_count  <= 5'(n_count);
        end
    end

    assign o_status   = r_o_status;
    assign o_data_out = r_o_data;
    assign o_count    = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head index out of range");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != r_rp))
        else $error("store read and write at the same slot");

endmodule

// ===== rtl/cdl_ctrl.sv =====
// Controller of the circular deque list: sequences check, shift run, write
// and result transfer. Uses cdl_pkg; drives cdl_datapath.
module cdl_ctrl
    import cdl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.chk_err) begin
                    n_state = S_DONE;
                end else if (i_stat.chk_nomove) begin
                    n_state = i_stat.chk_ins ? S_PUT : S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (i_stat.left_zero) n_state = i_stat.req_ins ? S_PUT : S_DONE;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_CHECK: o_cmd.setup      = 1'b1;
            S_READ:  o_cmd.read_first = 1'b1;
            S_MOVE:  o_cmd.move       = 1'b1;
            S_PUT:   o_cmd.put        = 1'b1;
            S_DONE:  o_cmd.commit     = out_free;
            default: o_cmd            = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted request not checked next");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (o_out_valid && r_state == S_IDLE))
        else $error("commit did not present a result");

    a_put_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |->
            ($past(r_state) == S_CHECK || $past(r_state) == S_MOVE))
        else $error("word written outside an insert");

endmodule
